// ===== src/wso_pkg.sv =====
// Shared types, constants and the control store of the wavetable sine oscillator.
// Used by wso_table_ram and wavetable_sine_oscillator; depends on nothing.
package wso_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 17;
  localparam int ACC_W       = 26;
  localparam int MUL_A_W     = 26;
  localparam int MUL_B_W     = 17;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int STEP_W      = 4;

  localparam logic signed [ENTRY_W-1:0] GEN_COS_INIT = 17'sd32767;
  localparam logic signed [MUL_B_W-1:0] GEN_COEF     = 17'sd1608;

  // configuration register indexes
  localparam logic [2:0] CFG_NUM_CHANNELS = 3'd0;
  localparam logic [2:0] CFG_STEP_LEFT    = 3'd1;
  localparam logic [2:0] CFG_STEP_RIGHT   = 3'd2;
  localparam logic [2:0] CFG_VOLUME_LEFT  = 3'd3;
  localparam logic [2:0] CFG_VOLUME_RIGHT = 3'd4;
  localparam logic [2:0] CFG_SAMPLE_DEPTH = 3'd5;
  localparam logic [2:0] CFG_UNSIGNED_OUT = 3'd6;

  // program steps
  localparam logic [STEP_W-1:0] STEP_FILL_COS = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FILL_SIN = 4'd1;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_READ     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_LO   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_HI   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_VOL  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_END      = 4'd9;

  typedef enum logic [1:0] {MA_SIN, MA_COS, MA_RD, MA_ACC} mul_a_sel_t;
  typedef enum logic [1:0] {MB_COEF, MB_WLO, MB_FRAC, MB_VOL} mul_b_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {GEN_HOLD, GEN_COS, GEN_SIN} gen_op_t;
  typedef enum logic [1:0] {AD_FILL, AD_IDX, AD_IDX1} addr_sel_t;
  typedef enum logic [2:0] {
    JC_NONE, JC_ALWAYS, JC_FILL_MORE, JC_NO_REQ, JC_OUT_BUSY, JC_MORE_CH
  } jump_cond_t;

  typedef struct packed {
    logic              take_req;
    logic              rd_en;
    logic              wr_en;
    addr_sel_t         addr_sel;
    mul_a_sel_t        mul_a;
    mul_b_sel_t        mul_b;
    acc_op_t           acc_op;
    gen_op_t           gen_op;
    logic              prod_ld;
    logic              emit;
    jump_cond_t        jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } wso_ram_req_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_FILL_COS: begin
        w.wr_en    = 1'b1;
        w.addr_sel = AD_FILL;
        w.mul_a    = MA_SIN;
        w.mul_b    = MB_COEF;
        w.gen_op   = GEN_COS;
      end
      STEP_FILL_SIN: begin
        w.mul_a  = MA_COS;
        w.mul_b  = MB_COEF;
        w.gen_op = GEN_SIN;
        w.jc     = JC_FILL_MORE;
        w.target = STEP_FILL_COS;
      end
      STEP_IDLE: begin
        w.take_req = 1'b1;
        w.jc       = JC_NO_REQ;
        w.target   = STEP_IDLE;
      end
      STEP_READ: begin
        w.rd_en    = 1'b1;
        w.addr_sel = AD_IDX;
      end
      STEP_MUL_LO: begin
        w.rd_en    = 1'b1;
        w.addr_sel = AD_IDX1;
        w.mul_a    = MA_RD;
        w.mul_b    = MB_WLO;
        w.acc_op   = ACC_LOAD;
      end
      STEP_MUL_HI: begin
        w.mul_a  = MA_RD;
        w.mul_b  = MB_FRAC;
        w.acc_op = ACC_ADD;
      end
      STEP_MUL_VOL: begin
        w.mul_a   = MA_ACC;
        w.mul_b   = MB_VOL;
        w.prod_ld = 1'b1;
      end
      STEP_WAIT: begin
        w.jc     = JC_OUT_BUSY;
        w.target = STEP_WAIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.jc     = JC_MORE_CH;
        w.target = STEP_READ;
      end
      STEP_END: begin
        w.jc     = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/wavetable_sine_oscillator.sv =====
// Wavetable sine oscillator top level: control-store sequencer, shared multiplier datapath.
// Depends on wso_pkg and wso_table_ram.
//
//  channel   direction  handshake            payload
//  in_       slave      in_tvalid/in_tready  in_tdata[0] buffer_end
//  out_      master     out_tvalid/tready    out_tdata sample, out_tuser, out_tlast frame_last
//  cfg_      write      cfg_we               cfg_index, cfg_wdata
//
// After reset the table fill runs over every entry; in_tready stays low meanwhile.
// In a frame every sample passes through the one 26x17 multiplier three times, plus a
// table read, a wait check and an output step.
// A full output register holds the sequencer in its wait step until the sample is taken.
// Reset is synchronous, active low; it restarts the table fill.
module wavetable_sine_oscillator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] buffer_end, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample
  output logic [1:0]  out_tuser,  // [0] channel, [1] buffer_end_res
  output logic        out_tlast,  // frame_last
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import wso_pkg::*;

  ucode_t              cw;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [ADDR_W-1:0]   fill_r;
  logic signed [ENTRY_W-1:0] cos_r, sin_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [15:0]         phase_r [2];
  logic                ch_r;
  logic                bend_r;

  logic [1:0]          num_ch_r;
  logic [15:0]         step_left_r, step_right_r, vol_left_r, vol_right_r;
  logic                depth_r, unsigned_r;

  logic                out_valid_r;
  logic [15:0]         out_sample_r;
  logic                out_ch_r, out_bend_r, out_last_r;

  wso_ram_req_t        ram_req;
  logic [ENTRY_W-1:0]  rd_data;

  logic [15:0]         cur_phase;
  logic [ADDR_W-1:0]   idx;
  logic [7:0]          frac;
  logic [15:0]         cur_vol, cur_step;
  logic                last_ch;
  logic                jump;
  logic                accept;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [18:0]         hi16;
  logic [10:0]         hi8;
  logic [15:0]         sat16;
  logic [7:0]          sat8;
  logic [15:0]         sample_nxt;

  assign cw = ucode_rom(step_r);

  assign cur_phase = ch_r ? phase_r[1] : phase_r[0];
  assign idx       = cur_phase[15:8];
  assign frac      = cur_phase[7:0];
  assign cur_vol   = ch_r ? vol_right_r : vol_left_r;
  assign cur_step  = ch_r ? step_right_r : step_left_r;
  // zero channels counts as mono, three as stereo
  assign last_ch   = ch_r | ~num_ch_r[1];

  assign in_tready = cw.take_req;
  assign accept    = in_tvalid & in_tready;

  // table port
  always_comb begin
    ram_req.we    = cw.wr_en;
    ram_req.re    = cw.rd_en;
    ram_req.wdata = sin_r;
    case (cw.addr_sel)
      AD_FILL: ram_req.addr = fill_r;
      AD_IDX:  ram_req.addr = idx;
      AD_IDX1: ram_req.addr = idx + 1'b1;  // wraps from the last entry back to entry 0
      default: ram_req.addr = idx;
    endcase
  end

  wso_table_ram u_table (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // shared multiplier
  always_comb begin
    case (cw.mul_a)
      MA_SIN:  mul_a = {{(MUL_A_W-ENTRY_W){sin_r[ENTRY_W-1]}}, sin_r};
      MA_COS:  mul_a = {{(MUL_A_W-ENTRY_W){cos_r[ENTRY_W-1]}}, cos_r};
      MA_RD:   mul_a = {{(MUL_A_W-ENTRY_W){rd_data[ENTRY_W-1]}}, rd_data};
      MA_ACC:  mul_a = acc_r;
      default: mul_a = acc_r;
    endcase
    case (cw.mul_b)
      MB_COEF: mul_b = GEN_COEF;
      MB_WLO:  mul_b = {8'd0, 9'(9'd256 - {1'b0, frac})};
      MB_FRAC: mul_b = {9'd0, frac};
      MB_VOL:  mul_b = {1'b0, cur_vol};
      default: mul_b = GEN_COEF;
    endcase
  end

  assign prod = mul_a * mul_b;

  // sequencer
  always_comb begin
    case (cw.jc)
      JC_NONE:      jump = 1'b0;
      JC_ALWAYS:    jump = 1'b1;
      JC_FILL_MORE: jump = (fill_r != '1);
      JC_NO_REQ:    jump = !in_tvalid;
      JC_OUT_BUSY:  jump = out_valid_r && !out_tready;
      JC_MORE_CH:   jump = !last_ch;
      default:      jump = 1'b0;
    endcase
    step_nxt = jump ? cw.target : step_r + 1'b1;
  end

  // clamp and format; arithmetic shifts give floor rounding
  always_comb begin
    hi16 = prod_r[42:24];
    hi8  = prod_r[42:32];
    if ((&hi16[18:15]) || !(|hi16[18:15])) begin
      sat16 = hi16[15:0];
    end else begin
      sat16 = hi16[18] ? 16'h8000 : 16'h7FFF;
    end
    if ((&hi8[10:7]) || !(|hi8[10:7])) begin
      sat8 = hi8[7:0];
    end else begin
      sat8 = hi8[10] ? 8'h80 : 8'h7F;
    end
    if (depth_r) begin
      sample_nxt = sat16 ^ {unsigned_r, 15'd0};
    end else begin
      sample_nxt = {8'h00, sat8 ^ {unsigned_r, 7'd0}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_FILL_COS;
      fill_r      <= '0;
      cos_r       <= GEN_COS_INIT;
      sin_r       <= '0;
      phase_r[0]  <= '0;
      phase_r[1]  <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      case (cw.gen_op)
        GEN_COS: cos_r <= cos_r - $signed(prod[32:16]);
        GEN_SIN: begin
          sin_r  <= sin_r + $signed(prod[32:16]);
          fill_r <= fill_r + 1'b1;
        end
        default: ;
      endcase
      if (cw.emit) begin
        phase_r[ch_r] <= cur_phase + cur_step;
        ch_r          <= !last_ch;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (accept) begin
      bend_r <= in_tdata[0];
    end
    case (cw.acc_op)
      ACC_LOAD: acc_r <= prod[ACC_W-1:0];
      ACC_ADD:  acc_r <= acc_r + prod[ACC_W-1:0];
      default:  ;
    endcase
    if (cw.prod_ld) begin
      prod_r <= prod;
    end
    if (cw.emit) begin
      out_sample_r <= sample_nxt;
      out_ch_r     <= ch_r;
      out_bend_r   <= bend_r;
      out_last_r   <= last_ch;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r     <= 2'd1;
      step_left_r  <= '0;
      step_right_r <= '0;
      vol_left_r   <= 16'd49152;
      vol_right_r  <= 16'd49152;
      depth_r      <= 1'b1;
      unsigned_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_CHANNELS: num_ch_r     <= cfg_wdata[1:0];
        CFG_STEP_LEFT:    step_left_r  <= cfg_wdata;
        CFG_STEP_RIGHT:   step_right_r <= cfg_wdata;
        CFG_VOLUME_LEFT:  vol_left_r   <= cfg_wdata;
        CFG_VOLUME_RIGHT: vol_right_r  <= cfg_wdata;
        CFG_SAMPLE_DEPTH: depth_r      <= cfg_wdata[0];
        CFG_UNSIGNED_OUT: unsigned_r   <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = {out_bend_r, out_ch_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // the wait step must have drained the output register before a load
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cw.emit |-> !out_valid_r) else $error("output register overwritten");

  // one request per frame: no second take right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("request taken twice");

  // the right channel always closes its frame
  a_right_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast) else $error("right sample not last");

  // a left sample that is not last only occurs in stereo
  a_left_stereo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> num_ch_r[1] && !out_tuser[0])
    else $error("frame continues in mono");

  // step counter stays inside the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_END) else $error("step counter out of program");
`endif

endmodule

// ===== src/wso_table_ram.sv =====
// Sine table storage: one port, write or registered read each cycle.
// Depends on wso_pkg for widths and the request struct.
module wso_table_ram (
  input  logic                          clk,
  input  wso_pkg::wso_ram_req_t         req,
  output logic [wso_pkg::ENTRY_W-1:0]   rd_data
);
  import wso_pkg::*;

  logic [ENTRY_W-1:0] mem_r [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== dv/wavetable_sine_oscillator_test.sv =====
// Self-checking testbench for wavetable_sine_oscillator: directed and random frame requests.
// A cycle-free predictor rebuilds the sine table and tracks phases and registers.
// Depends on wso_pkg (register indexes) and the oscillator RTL.
`timescale 1ns / 100ps

module wavetable_sine_oscillator_test;
  import wso_pkg::*;

  localparam int LUT_LEN        = 256;
  localparam int FILL_COS_START = 32767;
  localparam int FILL_COEF      = 1608;
  localparam logic [2:0] CFG_NONE = 3'd7;  // past the register list, must be ignored
  localparam int IDLE_PCT       = 19;
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int PHASE_ITEMS    = 100;
  localparam int RANDOM_PHASES  = 11;
  localparam int STEADY_PHASE   = 4;
  localparam int HOLD_PHASE     = 7;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic        channel;
    logic [15:0] sample;
    logic        bend;
    logic        last;
  } osc_sample_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [0] buffer_end, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [15:0] sample
  logic [1:0]  out_tuser;           // [0] channel, [1] buffer_end_res
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = 3'd0;
  logic [15:0] cfg_wdata  = 16'd0;

  // predictor state
  int          sine_lut [0:LUT_LEN];
  logic [15:0] osc_phase [0:1];
  logic [1:0]  m_nch;
  logic [15:0] m_step [0:1];
  logic [15:0] m_vol [0:1];
  logic        m_wide;
  logic        m_offset;

  osc_sample_t pending_samples [$];
  int          errors = 0;
  bit          steady = 1'b0;

  wavetable_sine_oscillator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // magic-circle recurrence, floor on every product
  function automatic void fill_sine_lut();
    longint c;
    longint s;
    c = FILL_COS_START;
    s = 0;
    for (int k = 0; k < LUT_LEN; k++) begin
      sine_lut[k] = int'(s);
      c = c - ((s * FILL_COEF) >>> 16);
      s = s + ((c * FILL_COEF) >>> 16);
    end
    sine_lut[LUT_LEN] = sine_lut[0];
  endfunction

  function automatic void reset_mirror();
    m_nch     = 2'd1;
    m_step[0] = 16'd0;
    m_step[1] = 16'd0;
    m_vol[0]  = 16'd49152;
    m_vol[1]  = 16'd49152;
    m_wide    = 1'b1;
    m_offset  = 1'b0;
    osc_phase[0] = 16'd0;
    osc_phase[1] = 16'd0;
    fill_sine_lut();
  endfunction

  function automatic void mirror_write(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      CFG_NUM_CHANNELS: m_nch     = val[1:0];
      CFG_STEP_LEFT:    m_step[0] = val;
      CFG_STEP_RIGHT:   m_step[1] = val;
      CFG_VOLUME_LEFT:  m_vol[0]  = val;
      CFG_VOLUME_RIGHT: m_vol[1]  = val;
      CFG_SAMPLE_DEPTH: m_wide    = val[0];
      CFG_UNSIGNED_OUT: m_offset  = val[0];
      default: ;
    endcase
  endfunction

  // interpolate, scale, clamp and advance each active channel of one frame
  function automatic void synth_frame(input logic bend);
    int          nch;
    int          idx;
    logic [15:0] p;
    longint      frac;
    longint      lvl;
    logic [15:0] bits;
    osc_sample_t rec;
    if (m_nch == 2'd0)
      nch = 1;
    else if (m_nch > 2'd2)
      nch = 2;
    else
      nch = int'(m_nch);
    for (int ch = 0; ch < nch; ch++) begin
      p    = osc_phase[ch];
      idx  = int'(p[15:8]);
      frac = longint'(p[7:0]);
      lvl  = longint'(sine_lut[idx]) * (256 - frac) + longint'(sine_lut[idx + 1]) * frac;
      lvl  = lvl * longint'(m_vol[ch]);
      if (m_wide) begin
        lvl = lvl >>> 24;
        if (lvl > 32767) lvl = 32767;
        if (lvl < -32768) lvl = -32768;
        bits = lvl[15:0];
        if (m_offset) bits[15] = ~bits[15];
      end else begin
        lvl = lvl >>> 32;
        if (lvl > 127) lvl = 127;
        if (lvl < -128) lvl = -128;
        bits = {8'h00, lvl[7:0]};
        if (m_offset) bits[7] = ~bits[7];
      end
      rec.channel = ch[0];
      rec.sample  = bits;
      rec.bend    = bend;
      rec.last    = (ch == nch - 1);
      pending_samples.push_back(rec);
      osc_phase[ch] = p + m_step[ch];
    end
  endfunction

  function automatic void compare_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endfunction

  // result side: check on handshake, then pick the next ready
  always @(posedge clk) begin : sample_monitor
    osc_sample_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t ns: unexpected sample, expected none actual %h", $time, out_tdata);
      end else begin
        want = pending_samples.pop_front();
        compare_field("channel", 16'(want.channel), 16'(out_tuser[0]));
        compare_field("sample", want.sample, out_tdata);
        compare_field("buffer_end", 16'(want.bend), 16'(out_tuser[1]));
        compare_field("frame_last", 16'(want.last), 16'(out_tlast));
      end
    end
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_frame(input logic bend);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, bend};
    do @(posedge clk); while (in_tready !== 1'b1);
    synth_frame(bend);
  endtask

  task automatic send_burst(input int n);
    repeat (n) send_frame(1'($urandom_range(0, 1)));
  endtask

  // hold requests until every sample is back, then let the sequencer settle
  task automatic drain();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_samples.size() != 0) begin
      errors++;
      $display("%0t ns: missing samples, expected %0d more actual none", $time,
               pending_samples.size());
      pending_samples.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_write(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_level(input int mode);
    if (mode == 0) return 16'hFFFF;
    if (mode == 1) return 16'h0000;
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mode 0: every register at its top (two channels), mode 1: at its bottom (one channel), otherwise random
  task automatic load_setup(input int mode);
    set_reg(CFG_NUM_CHANNELS, mode == 0 ? 16'd2 : mode == 1 ? 16'd1 :
                              16'($urandom_range(0, 65535)));
    set_reg(CFG_STEP_LEFT, pick_level(mode));
    set_reg(CFG_STEP_RIGHT, pick_level(mode));
    set_reg(CFG_VOLUME_LEFT, pick_level(mode));
    set_reg(CFG_VOLUME_RIGHT, pick_level(mode));
    set_reg(CFG_SAMPLE_DEPTH, mode == 0 ? 16'd1 : mode == 1 ? 16'd0 :
                              16'($urandom_range(0, 65535)));
    set_reg(CFG_UNSIGNED_OUT, mode == 0 ? 16'd1 : mode == 1 ? 16'd0 :
                              16'($urandom_range(0, 65535)));
    if ($urandom_range(0, 3) == 0)
      set_reg(CFG_NONE, 16'($urandom_range(0, 65535)));
  endtask

  // waits out the table fill, runs on reset defaults
  task automatic test_power_on();
    send_frame(1'b0);
    send_frame(1'b1);
    send_frame(1'b0);
    send_frame(1'b1);
  endtask

  // full-scale step wraps the phase onto the last table entry
  task automatic test_mono_extremes();
    drain();
    set_reg(CFG_STEP_LEFT, 16'hFFFF);
    set_reg(CFG_VOLUME_LEFT, 16'hFFFF);
    set_reg(CFG_UNSIGNED_OUT, 16'd1);
    send_burst(3);
  endtask

  task automatic test_eight_bit();
    drain();
    set_reg(CFG_SAMPLE_DEPTH, 16'd0);
    set_reg(CFG_STEP_LEFT, 16'h4080);
    set_reg(CFG_VOLUME_LEFT, 16'h0000);
    send_burst(2);
    drain();
    set_reg(CFG_VOLUME_LEFT, 16'hFFFF);
    set_reg(CFG_UNSIGNED_OUT, 16'd0);
    send_burst(3);
  endtask

  // stereo, count zero falls back to mono (right phase holds), count three saturates
  task automatic test_channel_count();
    drain();
    set_reg(CFG_NUM_CHANNELS, 16'd2);
    set_reg(CFG_STEP_RIGHT, 16'h00FF);
    set_reg(CFG_VOLUME_RIGHT, 16'hFFFF);
    set_reg(CFG_UNSIGNED_OUT, 16'd1);
    send_burst(3);
    drain();
    set_reg(CFG_NUM_CHANNELS, 16'd0);
    send_burst(2);
    drain();
    set_reg(CFG_NUM_CHANNELS, 16'hFFFF);
    send_burst(2);
  endtask

  task automatic test_ignored_index();
    drain();
    set_reg(CFG_NONE, 16'hFFFF);
    set_reg(CFG_SAMPLE_DEPTH, 16'd1);
    set_reg(CFG_NONE, 16'h0000);
    send_burst(2);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      steady = (ph == STEADY_PHASE);
      load_setup(ph);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == HOLD_PHASE && i == PHASE_ITEMS / 2)
          drain();
        send_frame(1'($urandom_range(0, 1)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    reset_mirror();
    test_power_on();
    test_mono_extremes();
    test_eight_bit();
    test_channel_count();
    test_ignored_index();
    test_random_traffic();
    drain();
    if (errors == 0)
      $display("wavetable_sine_oscillator_test passed");
    else
      $display("wavetable_sine_oscillator_test failed");
    $finish;
  end

  initial begin
    #1000000;
    $display("wavetable_sine_oscillator_test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wso_pkg.sv
src/wso_table_ram.sv
src/wavetable_sine_oscillator.sv
dv/wavetable_sine_oscillator_test.sv
